/* sv/lppm_pkg.sv */
// ----------------------------------------------------------------------------
// lppm_pkg
// Shared types and constants of the polar-to-pixel mapper: register indexes,
// outcome codes, image geometry and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lppm_pkg;

  localparam int ImageWidth  = 600;
  localparam int ImageHeight = 600;

  localparam int AtanEntries = 24;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;

  typedef enum logic [2:0] {
    RegRangeMin  = 3'd0,
    RegRangeMax  = 3'd1,
    RegAngleStart = 3'd2,
    RegAngleStep = 3'd3,
    RegPixelScale = 3'd4
  } lppm_reg_e;

  typedef enum logic [1:0] {
    OutPlotted  = 2'd0,
    OutRejected = 2'd1,
    OutOffImage = 2'd2
  } lppm_outcome_e;

  // sideband that rides alongside the angle through the rotator
  typedef struct packed {
    logic        reject;
    logic [31:0] range_scale;
  } lppm_side_t;

  localparam logic [31:0] AtanTable [AtanEntries] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

/* sv/lppm_cordic.sv */
// ----------------------------------------------------------------------------
// lppm_cordic
// Pipelined rotation-mode CORDIC: one micro-rotation per register stage,
// with a half-turn fold in front and the matching sign flip behind.
// ----------------------------------------------------------------------------
module lppm_cordic #(
  parameter int Stages = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [15:0]         angle_i,
  input  lppm_pkg::lppm_side_t side_i,
  output logic                valid_o,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o,
  output lppm_pkg::lppm_side_t side_o
);
  import lppm_pkg::*;

  localparam int NumStages = (Stages > AtanEntries) ? AtanEntries : Stages;

  logic                valid_q [NumStages+1];
  logic                flip_q  [NumStages+1];
  lppm_side_t          side_q  [NumStages+1];
  logic signed [31:0]  x_q     [NumStages+1];
  logic signed [31:0]  y_q     [NumStages+1];
  logic signed [32:0]  z_q     [NumStages+1];

  logic [31:0] wide_angle;
  logic        fold;
  logic [31:0] folded;

  // angles in the second and third quadrant are turned by half a turn
  assign wide_angle = {angle_i, 16'h0000};
  assign fold       = (wide_angle[31:30] == 2'b01) || (wide_angle[31:30] == 2'b10);
  assign folded     = fold ? {~wide_angle[31], wide_angle[30:0]} : wide_angle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q[0] <= fold;
    side_q[0] <= side_i;
    x_q[0]    <= CordicGain;
    y_q[0]    <= '0;
    z_q[0]    <= {folded[31], folded};
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    logic               dir;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [32:0] atan;

    assign dir  = ~z_q[i][32];
    assign xs   = x_q[i] >>> i;
    assign ys   = y_q[i] >>> i;
    assign atan = $signed({1'b0, AtanTable[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      side_q[i+1] <= side_q[i];
      x_q[i+1]    <= dir ? (x_q[i] - ys) : (x_q[i] + ys);
      y_q[i+1]    <= dir ? (y_q[i] + xs) : (y_q[i] - xs);
      z_q[i+1]    <= dir ? (z_q[i] - atan) : (z_q[i] + atan);
    end
  end

  logic               valid_out_q;
  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;
  lppm_side_t         side_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else begin
      valid_out_q <= valid_q[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q      <= flip_q[NumStages] ? -x_q[NumStages] : x_q[NumStages];
    sin_q      <= flip_q[NumStages] ? -y_q[NumStages] : y_q[NumStages];
    side_out_q <= side_q[NumStages];
  end

  assign valid_o = valid_out_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = side_out_q;

endmodule

/* sv/lidar_polar_to_pixel_mapper_unit.sv */
// the result strobe passes the input register, the rotator, the multiply and truncate registers and the output register
// throughput: one sample per cycle, start may stay high; busy never rises
// the micro-rotation stages of the rotator (CORDIC_STAGES, capped at the arctangent table) set the depth
// reset clears all valid bits and restores the configuration registers
// ----------------------------------------------------------------------------
// lidar_polar_to_pixel_mapper_unit
// Maps lidar range samples to pixels of a top view centred on the sensor:
// range gating, beam angle, CORDIC sine/cosine, scaling and bounds check.
// ----------------------------------------------------------------------------
module lidar_polar_to_pixel_mapper_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [11:0]                   sample_index_i,
  input  logic [15:0]                   range_q8_i,
  input  logic                          not_finite_i,
  output logic                          valid_o,
  output logic [9:0]                    pixel_x_o,
  output logic [9:0]                    pixel_y_o,
  output lppm_pkg::lppm_outcome_e       outcome_o
);
  import lppm_pkg::*;

  localparam logic signed [19:0] CentreX = 20'(ImageWidth / 2);
  localparam logic signed [19:0] CentreY = 20'(ImageHeight / 2);
  localparam logic signed [19:0] LimitX  = 20'(ImageWidth);
  localparam logic signed [19:0] LimitY  = 20'(ImageHeight);

  // configuration registers
  logic [15:0] win_lo_q, win_hi_q, angle_start_q, angle_step_q, pixel_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q      <= 16'd0;
      win_hi_q      <= 16'hFFFF;
      angle_start_q <= 16'h8000;
      angle_step_q  <= 16'd91;
      pixel_scale_q <= 16'd1920;
    end else if (cfg_we_i) begin
      case (lppm_reg_e'(cfg_idx_i))
        RegRangeMin:   win_lo_q      <= cfg_wdata_i;
        RegRangeMax:   win_hi_q      <= cfg_wdata_i;
        RegAngleStart: angle_start_q <= cfg_wdata_i;
        RegAngleStep:  angle_step_q  <= cfg_wdata_i;
        RegPixelScale: pixel_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: gate, beam angle, range times scale
  logic        in_beat;
  logic [15:0] step_prod;
  logic        s1_valid_q;
  logic [15:0] s1_angle_q;
  lppm_side_t  s1_side_q;

  assign in_beat   = start && !busy;
  assign step_prod = angle_step_q * 16'(sample_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_angle_q              <= angle_start_q + step_prod;
    s1_side_q.reject        <= not_finite_i || (range_q8_i < win_lo_q)
                               || (range_q8_i > win_hi_q);
    s1_side_q.range_scale   <= 32'(range_q8_i) * 32'(pixel_scale_q);
  end

  logic               rot_valid;
  logic signed [31:0] rot_cos;
  logic signed [31:0] rot_sin;
  lppm_side_t         rot_side;

  lppm_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .angle_i (s1_angle_q),
    .side_i  (s1_side_q),
    .valid_o (rot_valid),
    .cos_o   (rot_cos),
    .sin_o   (rot_sin),
    .side_o  (rot_side)
  );

  // multiply stage: Q46 products
  logic signed [32:0] rs_s;
  logic signed [64:0] fwd_full, left_full;
  logic               m_valid_q, m_reject_q;
  logic signed [63:0] m_fwd_q, m_left_q;

  assign rs_s      = $signed({1'b0, rot_side.range_scale});
  assign fwd_full  = 65'(rot_cos) * 65'(rs_s);
  assign left_full = 65'(rot_sin) * 65'(rs_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= rot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_reject_q <= rot_side.reject;
    m_fwd_q    <= fwd_full[63:0];
    m_left_q   <= left_full[63:0];
  end

  // truncate toward zero: bias negatives by 2^46 - 1 before the shift
  logic signed [63:0] fwd_biased, left_biased;
  logic               t_valid_q, t_reject_q;
  logic signed [17:0] t_fwd_q, t_left_q;

  assign fwd_biased  = m_fwd_q + $signed({18'd0, {46{m_fwd_q[63]}}});
  assign left_biased = m_left_q + $signed({18'd0, {46{m_left_q[63]}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
    end else begin
      t_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_reject_q <= m_reject_q;
    t_fwd_q    <= fwd_biased[63:46];
    t_left_q   <= left_biased[63:46];
  end

  // place around the centre and check the image bounds
  logic signed [19:0] col, row;
  logic               off_image;
  logic               valid_q;
  logic [9:0]         pixel_x_q, pixel_y_q;
  lppm_outcome_e      outcome_q;

  assign col       = CentreX - 20'(t_left_q);
  assign row       = CentreY - 20'(t_fwd_q);
  assign off_image = col[19] || (col >= LimitX) || row[19] || (row >= LimitY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= t_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_reject_q) begin
      pixel_x_q <= '0;
      pixel_y_q <= '0;
      outcome_q <= OutRejected;
    end else if (off_image) begin
      pixel_x_q <= '0;
      pixel_y_q <= '0;
      outcome_q <= OutOffImage;
    end else begin
      pixel_x_q <= col[9:0];
      pixel_y_q <= row[9:0];
      outcome_q <= OutPlotted;
    end
  end

  assign valid_o   = valid_q;
  assign pixel_x_o = pixel_x_q;
  assign pixel_y_o = pixel_y_q;
  assign outcome_o = outcome_q;

endmodule
